// File: hdl/lslq_pkg.sv
// Package for the light sensor LED qualifier: command codes, qualification
// states, register indexes, reset values and the structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package lslq_pkg;

  // command codes carried in the mode field
  localparam logic [1:0] MODE_ON     = 2'd0;
  localparam logic [1:0] MODE_DETECT = 2'd1;
  localparam logic [1:0] MODE_OFF    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DARK_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_BRIGHT_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_QUALIFY_COUNT    = 2'd2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned RUN_W       = 5;

  localparam logic [SAMPLE_W-1:0] DARK_THRESHOLD_RST   = 8'hA0;
  localparam logic [SAMPLE_W-1:0] BRIGHT_THRESHOLD_RST = 8'hA8;
  localparam logic [RUN_W-1:0]    QUALIFY_COUNT_RST    = 5'd20;

  typedef enum logic [1:0] {
    QS_NONE = 2'd0,
    QS_QUAL = 2'd1,
    QS_LOCK = 2'd2
  } qual_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dark_threshold;
    logic [SAMPLE_W-1:0] bright_threshold;
    logic [RUN_W-1:0]    qualify_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [SAMPLE_W-1:0] sample;
    logic                in_call;
  } item_t;

  typedef struct packed {
    logic camera_led;
    logic door_led;
    logic night_led;
    logic locked;
  } result_t;

endpackage

// File: hdl/lslq_cfg_regs.sv
// Configuration register file: thresholds and qualify count.
// Depends on lslq_pkg.
`timescale 1ns / 1ps

module lslq_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lslq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lslq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lslq_pkg::cfg_t                 cfg
);
  import lslq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dark_threshold   <= DARK_THRESHOLD_RST;
      cfg.bright_threshold <= BRIGHT_THRESHOLD_RST;
      cfg.qualify_count    <= QUALIFY_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DARK_THRESHOLD:   cfg.dark_threshold   <= cfg_data;
        REG_BRIGHT_THRESHOLD: cfg.bright_threshold <= cfg_data;
        REG_QUALIFY_COUNT:    cfg.qualify_count    <= cfg_data[RUN_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

endmodule

// File: hdl/lslq_in_reg.sv
// Input register stage: captures one transaction and holds it until the
// core takes it. Depends on lslq_pkg.
`timescale 1ns / 1ps

module lslq_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  lslq_pkg::item_t in_item,
  output logic            pipe_valid,
  output lslq_pkg::item_t pipe_item,
  input  logic            take
);
  import lslq_pkg::*;

  logic load;

  assign in_stall = pipe_valid & ~take;
  assign load     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (load) begin
      pipe_valid <= 1'b1;
    end else if (take) begin
      pipe_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pipe_item <= in_item;
    end
  end

endmodule

// File: hdl/lslq_core.sv
// Qualifier core: hysteresis flag, debounce run counter, qualification state,
// lamp registers and the result register. Depends on lslq_pkg.
`timescale 1ns / 1ps

module lslq_core (
  input  logic             clk,
  input  logic             rst,
  input  lslq_pkg::cfg_t   cfg,
  input  logic             pipe_valid,
  input  lslq_pkg::item_t  pipe_item,
  output logic             take,
  output logic             out_valid,
  input  logic             out_stall,
  output lslq_pkg::result_t result
);
  import lslq_pkg::*;

  logic             dark_flag, dark_flag_next;
  logic [RUN_W-1:0] dark_run, dark_run_next;
  qual_state_t      qstate, qstate_next;
  logic             camera_led, camera_led_next;
  logic             door_led, door_led_next;
  logic             night_led, night_led_next;

  logic             flag_set;
  logic [RUN_W-1:0] run_inc;

  assign take = pipe_valid & (~out_valid | ~out_stall);

  always_comb begin
    dark_flag_next  = dark_flag;
    dark_run_next   = dark_run;
    qstate_next     = qstate;
    camera_led_next = camera_led;
    door_led_next   = door_led;
    night_led_next  = night_led;

    // hysteresis: below dark sets, then above bright clears
    flag_set = (pipe_item.sample < cfg.dark_threshold) ? 1'b1 : dark_flag;
    if (flag_set && (pipe_item.sample > cfg.bright_threshold)) begin
      flag_set = 1'b0;
    end
    // run < count <= 31, so the increment never wraps
    run_inc = (dark_run < cfg.qualify_count) ? dark_run + 1'b1 : dark_run;

    unique case (pipe_item.mode)
      MODE_ON: begin
        if (qstate == QS_QUAL) begin
          camera_led_next = 1'b1;
          qstate_next     = QS_LOCK;
        end
      end
      MODE_DETECT: begin
        if (qstate != QS_LOCK) begin
          dark_flag_next = flag_set;
          if (flag_set) begin
            dark_run_next = run_inc;
            if (run_inc >= cfg.qualify_count) begin
              night_led_next = 1'b1;
              if (pipe_item.in_call) begin
                camera_led_next = 1'b1;
                door_led_next   = 1'b1;
                qstate_next     = QS_LOCK;
              end else begin
                door_led_next = 1'b0;
                qstate_next   = QS_QUAL;
              end
            end
          end else begin
            dark_run_next  = '0;
            qstate_next    = QS_NONE;
            night_led_next = 1'b0;
            door_led_next  = 1'b0;
          end
        end
      end
      MODE_OFF: begin
        dark_run_next   = '0;
        qstate_next     = QS_NONE;
        camera_led_next = 1'b0;
      end
      default: ; // unused code: state holds
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_flag  <= 1'b0;
      dark_run   <= '0;
      qstate     <= QS_NONE;
      camera_led <= 1'b0;
      door_led   <= 1'b0;
      night_led  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        dark_flag  <= dark_flag_next;
        dark_run   <= dark_run_next;
        qstate     <= qstate_next;
        camera_led <= camera_led_next;
        door_led   <= door_led_next;
        night_led  <= night_led_next;
        out_valid  <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with the state it reflects
  always_ff @(posedge clk) begin
    if (take) begin
      result.camera_led <= camera_led_next;
      result.door_led   <= door_led_next;
      result.night_led  <= night_led_next;
      result.locked     <= (qstate_next == QS_LOCK);
    end
  end

endmodule

// File: hdl/light_sensor_led_qualifier.sv
// Top level of the light sensor LED qualifier: config registers, input
// register and qualifier core. Depends on lslq_pkg and the lslq_* modules.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   in       | in_valid / in_stall    | mode, sample, in_call
//   out      | out_valid / out_stall  | camera_led, door_led, night_led, locked
//   cfg      | cfg_we (no stall)      | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low. A transaction is
// captured in the input register; when the core takes it, the qualifier update
// runs and loads the result register, which presents the result until the
// receiver takes it.
// The result register is the only point of backpressure: out_stall holds it,
// the input register then fills and in_stall rises until the result is taken.
// rst is synchronous, active high: thresholds return to 160/168, qualify
// count to 20, and all flags, counters, lamps and valids clear.
`timescale 1ns / 1ps

module light_sensor_led_qualifier (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [lslq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lslq_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input transactions
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       mode,
  input  logic [lslq_pkg::SAMPLE_W-1:0]    sample,
  input  logic                             in_call,
  // result transactions
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             camera_led,
  output logic                             door_led,
  output logic                             night_led,
  output logic                             locked
);
  import lslq_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   pipe_item;
  result_t result;
  logic    pipe_valid;
  logic    take;

  assign in_item.mode    = mode;
  assign in_item.sample  = sample;
  assign in_item.in_call = in_call;

  lslq_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // one-deep input stage; frees itself whenever the core takes its item
  lslq_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .pipe_valid (pipe_valid),
    .pipe_item  (pipe_item),
    .take       (take)
  );

  // state update and result register
  lslq_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pipe_valid (pipe_valid),
    .pipe_item  (pipe_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign camera_led = result.camera_led;
  assign door_led   = result.door_led;
  assign night_led  = result.night_led;
  assign locked     = result.locked;

endmodule

// File: verif/tb.sv
// Testbench for light_sensor_led_qualifier: directed table, then random phases,
// each result checked against a typed row result or a model of the lamp logic.
// Depends on lslq_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
  import lslq_pkg::*;

  // Codes the block must tolerate but that the package leaves unnamed.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  localparam int ITEMS_PER_PHASE = 66;
  localparam int NUM_PHASES      = 8;
  localparam int CYCLE_LIMIT     = 200000;

  // One row of the directed table. Where known is set, lamps holds the
  // hand-computed result; otherwise the model supplies it.
  typedef struct packed {
    item_t   it;
    logic    known;
    result_t lamps;
  } row_t;

  // Register settings and traffic shape for one random phase.
  typedef struct packed {
    cfg_t       cfg;
    logic       idle_on;
    logic [6:0] stall_pct;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_UNUSED;
  logic [SAMPLE_W-1:0] sample = '0;
  logic in_call = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic camera_led, door_led, night_led, locked;

  light_sensor_led_qualifier dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .sample(sample), .in_call(in_call),
    .out_valid(out_valid), .out_stall(out_stall),
    .camera_led(camera_led), .door_led(door_led),
    .night_led(night_led), .locked(locked)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Model of the qualifier: its own copy of the registers and the lamp state.
  // ---------------------------------------------------------------------------
  cfg_t           lamp_cfg = '{dark_threshold: DARK_THRESHOLD_RST,
                               bright_threshold: BRIGHT_THRESHOLD_RST,
                               qualify_count: QUALIFY_COUNT_RST};
  logic           dark_seen = 1'b0;
  logic [RUN_W-1:0] dark_len = '0;
  qual_state_t    qual = QS_NONE;
  logic           cam_on = 1'b0, door_on = 1'b0, night_on = 1'b0;

  result_t pending_lamps[$];   // expected results, oldest first
  int errors = 0;
  int sent = 0;                // transactions accepted in the current phase
  int cycle_count = 0;

  // traffic shape, changed per phase
  logic       idle_on = 1'b1;
  logic [6:0] stall_pct = 7'd0;
  int         burst_left = 0;
  int         stall_hold = 0;

  // Advance the model by one transaction and return the lamp levels.
  task automatic step_lamps(input item_t it, output result_t lamps);
    case (it.mode)
      MODE_ON: begin
        if (qual == QS_QUAL) begin
          cam_on = 1'b1;
          qual = QS_LOCK;
        end
      end
      MODE_DETECT: begin
        // once locked, detection is frozen, hysteresis flag included
        if (qual != QS_LOCK) begin
          if (it.sample < lamp_cfg.dark_threshold) dark_seen = 1'b1;
          // overlapping thresholds: set, then cleared again here
          if (dark_seen && it.sample > lamp_cfg.bright_threshold) dark_seen = 1'b0;
          if (dark_seen) begin
            // saturating run; a lowered count qualifies at once
            if (dark_len < lamp_cfg.qualify_count) dark_len = dark_len + 1'b1;
            if (dark_len >= lamp_cfg.qualify_count) begin
              qual = QS_QUAL;
              night_on = 1'b1;
              if (it.in_call) begin
                cam_on = 1'b1;
                door_on = 1'b1;
                qual = QS_LOCK;
              end else begin
                door_on = 1'b0;
              end
            end
          end else begin
            dark_len = '0;
            qual = QS_NONE;
            night_on = 1'b0;
            door_on = 1'b0;
          end
        end
      end
      MODE_OFF: begin
        // flag, door and night lamps are left alone
        dark_len = '0;
        qual = QS_NONE;
        cam_on = 1'b0;
      end
      default: ;  // unused code: state holds
    endcase
    lamps.camera_led = cam_on;
    lamps.door_led   = door_on;
    lamps.night_led  = night_on;
    lamps.locked     = (qual == QS_LOCK);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void check_lamp(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  result_t want_lamps;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_lamps.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want_lamps = pending_lamps.pop_front();
        check_lamp("camera_led", want_lamps.camera_led, camera_led);
        check_lamp("door_led",   want_lamps.door_led,   door_led);
        check_lamp("night_led",  want_lamps.night_led,  night_led);
        check_lamp("locked",     want_lamps.locked,     locked);
      end
    end
  end

  // Receiver backpressure: random per-cycle stall plus occasional long holds.
  always @(negedge clk) begin
    if (stall_pct == 0) begin
      stall_hold = 0;
      out_stall = 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold--;
      out_stall = 1'b1;
    end else begin
      if ($urandom_range(199) == 0) stall_hold = $urandom_range(20, 5);
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. All tasks are entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  function automatic item_t make_item(logic [1:0] m, logic [SAMPLE_W-1:0] s, logic c);
    item_t it;
    it.mode = m;
    it.sample = s;
    it.in_call = c;
    return it;
  endfunction

  // Drive one transaction, wait for acceptance, record its expectation.
  // A known row posts its typed result; the model still steps either way.
  task automatic send_item(input item_t it, input logic known = 1'b0,
                           input result_t typed = '0);
    result_t lamps;
    in_valid = 1'b1;
    mode = it.mode;
    sample = it.sample;
    in_call = it.in_call;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_lamps(it, lamps);
    pending_lamps.push_back(known ? typed : lamps);
    sent++;
    @(negedge clk);
    // bursts of random length separated by random gaps
    if (idle_on && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
      burst_left = $urandom_range(12, 1);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Hold the input side until every expected result has been taken.
  task automatic drain;
    in_valid = 1'b0;
    while (pending_lamps.size() != 0) @(negedge clk);
  endtask

  // Register write; only issued with the block drained.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_DARK_THRESHOLD:   lamp_cfg.dark_threshold = data;
      REG_BRIGHT_THRESHOLD: lamp_cfg.bright_threshold = data;
      REG_QUALIFY_COUNT:    lamp_cfg.qualify_count = data[RUN_W-1:0];
      default: ;  // out-of-range index is dropped
    endcase
  endtask

  function automatic logic [SAMPLE_W-1:0] dark_sample();
    if (lamp_cfg.dark_threshold == 0) return SAMPLE_W'($urandom_range(255));
    return SAMPLE_W'($urandom_range(lamp_cfg.dark_threshold - 1, 0));
  endfunction

  function automatic logic [SAMPLE_W-1:0] bright_sample();
    if (lamp_cfg.bright_threshold == 8'hFF) return SAMPLE_W'($urandom_range(255));
    return SAMPLE_W'($urandom_range(255, lamp_cfg.bright_threshold + 1));
  endfunction

  function automatic item_t noise_item();
    return make_item(2'($urandom_range(3)), SAMPLE_W'($urandom_range(255)),
                     1'($urandom_range(1)));
  endfunction

  // Well-formed sequence: a run of dark samples, up to two longer than the qualify
  // count, then a random closing command.
  task automatic dark_sequence;
    int n;
    n = $urandom_range(lamp_cfg.qualify_count + 2, 1);
    repeat (n) send_item(make_item(MODE_DETECT, dark_sample(), $urandom_range(11) == 0));
    case ($urandom_range(5))
      0: send_item(make_item(MODE_ON, SAMPLE_W'($urandom_range(255)),
                             1'($urandom_range(1))));
      1: send_item(make_item(MODE_DETECT, dark_sample(), 1'b1));
      2: send_item(make_item(MODE_OFF, SAMPLE_W'($urandom_range(255)),
                             1'($urandom_range(1))));
      3: send_item(make_item(MODE_DETECT, bright_sample(), 1'($urandom_range(1))));
      4: send_item(make_item(MODE_DETECT, SAMPLE_W'($urandom_range(255)),
                             1'($urandom_range(1))));
      default: send_item(noise_item());
    endcase
  endtask

  // Phase plan: reset values, extremes, overlapping thresholds, zero count,
  // and a drop of the count right after the longest one so the run exceeds it.
  function automatic phase_t phase_plan(int k);
    phase_t p;
    case (k)
      0: p = '{cfg: '{8'd160, 8'd168, 5'd20}, idle_on: 1'b1, stall_pct: 7'd30};
      1: p = '{cfg: '{8'd0,   8'd255, 5'd1},  idle_on: 1'b0, stall_pct: 7'd0};
      2: p = '{cfg: '{8'd255, 8'd0,   5'd31}, idle_on: 1'b1, stall_pct: 7'd50};
      3: p = '{cfg: '{8'd200, 8'd100, 5'd0},  idle_on: 1'b1, stall_pct: 7'd20};
      4: p = '{cfg: '{8'd100, 8'd200, 5'd31}, idle_on: 1'b1, stall_pct: 7'd40};
      5: p = '{cfg: '{8'd128, 8'd128, 5'd2},  idle_on: 1'b0, stall_pct: 7'd60};
      6: p = '{cfg: '{8'd255, 8'd255, 5'd3},  idle_on: 1'b1, stall_pct: 7'd10};
      default: p = '{cfg: '{8'd60, 8'd90, 5'd8}, idle_on: 1'b1, stall_pct: 7'd70};
    endcase
    return p;
  endfunction

  function automatic row_t row(logic [1:0] m, logic [SAMPLE_W-1:0] s, logic c,
                               logic known, result_t lamps);
    row_t r;
    r.it = make_item(m, s, c);
    r.known = known;
    r.lamps = lamps;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  row_t   directed[$];
  phase_t plan;
  logic   paused;

  initial begin
    // Synchronous reset, released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, default thresholds 160/168, count dropped to one so a
    // single dark sample qualifies. Lamp order: camera, door, night, locked.
    directed = '{
      row(MODE_UNUSED, 8'h00, 1'b0, 1'b1, 4'b0000),  // reset levels, no-op code
      row(MODE_DETECT, 8'hFF, 1'b0, 1'b1, 4'b0000),  // full-scale bright
      row(MODE_ON,     8'h00, 1'b0, 1'b1, 4'b0000),  // on before qualified
      row(MODE_DETECT, 8'h00, 1'b0, 1'b0, 4'b0000),  // darkest, qualifies
      row(MODE_UNUSED, 8'hAA, 1'b1, 1'b0, 4'b0000),
      row(MODE_ON,     8'h55, 1'b0, 1'b0, 4'b0000),  // light on and lock
      row(MODE_DETECT, 8'hFF, 1'b0, 1'b0, 4'b0000),  // detect while locked
      row(MODE_OFF,    8'h00, 1'b0, 1'b0, 4'b0000),
      row(MODE_DETECT, 8'hA4, 1'b1, 1'b0, 4'b0000),  // inside band, in call
      row(MODE_OFF,    8'h00, 1'b1, 1'b0, 4'b0000),
      row(MODE_DETECT, 8'hA8, 1'b0, 1'b0, 4'b0000),  // at bright, flag holds
      row(MODE_DETECT, 8'hA9, 1'b0, 1'b0, 4'b0000),  // just above bright
      row(MODE_DETECT, 8'hA0, 1'b0, 1'b1, 4'b0000),  // at dark, not below
      row(MODE_DETECT, 8'h9F, 1'b1, 1'b0, 4'b0000),  // just below dark, in call
      row(MODE_OFF,    8'hFF, 1'b1, 1'b0, 4'b0000),
      row(MODE_ON,     8'h00, 1'b1, 1'b0, 4'b0000),  // on after off
      row(MODE_DETECT, 8'hFF, 1'b1, 1'b1, 4'b0000),
      row(MODE_UNUSED, 8'hFF, 1'b1, 1'b1, 4'b0000)
    };
    write_reg(REG_QUALIFY_COUNT, 8'd1);
    idle_on = 1'b1;
    stall_pct = 7'd25;
    foreach (directed[i]) send_item(directed[i].it, directed[i].known, directed[i].lamps);
    drain();
    write_reg(REG_UNUSED, 8'hFF);  // must not touch any register

    // Random phases; registers change only once the block is drained.
    for (int k = 0; k < NUM_PHASES; k++) begin
      drain();
      plan = phase_plan(k);
      write_reg(REG_DARK_THRESHOLD, plan.cfg.dark_threshold);
      write_reg(REG_BRIGHT_THRESHOLD, plan.cfg.bright_threshold);
      // upper data bits are don't-care for the count
      write_reg(REG_QUALIFY_COUNT, {3'($urandom_range(7)), plan.cfg.qualify_count});
      idle_on = plan.idle_on;
      stall_pct = plan.stall_pct;
      sent = 0;
      paused = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        // mid-phase hold-off until the output side is empty
        if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(3) == 0) send_item(noise_item());
        else dark_sequence();
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (errors == 0 && pending_lamps.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
